[rtl/tdwp_pkg.sv]
// Shared types and constants for the TDD window phase decoder.
// Used by every module under rtl; depends on nothing.
package tdwp_pkg;

	// Quotient bits retired per divider stage.
	localparam int DIV_DIGITS = 4;

	// Width of the remaining-time result field.
	localparam int HOLD_BITS = 18;

	// Register map of the configuration port.
	localparam int CFG_INDEX_BITS = 2;
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_TX_WINDOW  = 2'd0,
		REG_ACK_WINDOW = 2'd1,
		REG_GUARD      = 2'd2
	} cfg_reg_t;

	// Register values after reset, in milliseconds.
	localparam int TX_WINDOW_RESET  = 100;
	localparam int ACK_WINDOW_RESET = 50;
	localparam int GUARD_RESET      = 10;

	// Position of a timestamp inside the frame.
	typedef enum logic [1:0] {
		PH_TX     = 2'd0,
		PH_GUARD1 = 2'd1,
		PH_ACK    = 2'd2,
		PH_GUARD2 = 2'd3
	} phase_t;

endpackage

[rtl/tdwp_div_stage.sv]
// One stage of the pipelined restoring divider that reduces a timestamp modulo the frame.
// Depends on tdwp_pkg for the number of digits retired per stage.
module tdwp_div_stage #(
	parameter int FRAME_BITS = 18,
	parameter int DIV_BITS   = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  vld_in,
	input  logic [FRAME_BITS-1:0] rem_in,
	input  logic [DIV_BITS-1:0]   div_in,
	input  logic [FRAME_BITS-1:0] frame,
	output logic                  vld_out,
	output logic [FRAME_BITS-1:0] rem_out,
	output logic [DIV_BITS-1:0]   div_out
);

	logic [FRAME_BITS-1:0] rem_nxt;
	logic [DIV_BITS-1:0]   div_nxt;

	// Each step shifts in the next dividend bit and subtracts the frame when it fits.
	always_comb begin
		logic [FRAME_BITS:0] r_ext;
		rem_nxt = rem_in;
		div_nxt = div_in;
		for (int i = 0; i < tdwp_pkg::DIV_DIGITS; i++) begin
			r_ext = {rem_nxt, div_nxt[DIV_BITS-1]};
			div_nxt = {div_nxt[DIV_BITS-2:0], 1'b0};
			if (r_ext >= {1'b0, frame}) begin
				r_ext = r_ext - {1'b0, frame};
			end
			rem_nxt = r_ext[FRAME_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= rem_nxt;
			div_out <= div_nxt;
		end
	end

endmodule

[rtl/tdwp_phase.sv]
// Phase classification and remaining-time stages that follow the divider.
// Depends on tdwp_pkg for the phase codes and the result field width.
module tdwp_phase #(
	parameter int FRAME_BITS = 18
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_in,
	input  logic [FRAME_BITS-1:0]         offset,
	input  logic [FRAME_BITS-1:0]         end_tx,
	input  logic [FRAME_BITS-1:0]         end_g1,
	input  logic [FRAME_BITS-1:0]         end_ack,
	input  logic [FRAME_BITS-1:0]         frame,
	output logic                          vld_out,
	output tdwp_pkg::phase_t              phase,
	output logic [tdwp_pkg::HOLD_BITS-1:0] rx_hold_ms,
	output logic                          cfg_error
);

	localparam int EXT_BITS = (FRAME_BITS > tdwp_pkg::HOLD_BITS) ? FRAME_BITS
		: tdwp_pkg::HOLD_BITS;
	localparam logic [EXT_BITS-1:0] HOLD_MAX = EXT_BITS'((64'd1 << tdwp_pkg::HOLD_BITS) - 64'd1);

	tdwp_pkg::phase_t      phase_nxt;
	logic [FRAME_BITS-1:0] bound_nxt;
	logic                  err_nxt;

	logic                  vld_s1;
	tdwp_pkg::phase_t      phase_s1;
	logic [FRAME_BITS-1:0] bound_s1;
	logic [FRAME_BITS-1:0] offset_s1;
	logic                  err_s1;

	logic [EXT_BITS-1:0]           diff_ext;
	logic [tdwp_pkg::HOLD_BITS-1:0] hold_nxt;

	// The first window whose end lies beyond the offset wins; empty windows drop out.
	always_comb begin
		err_nxt = (frame == '0);
		if (err_nxt || offset < end_tx) begin
			phase_nxt = tdwp_pkg::PH_TX;
			bound_nxt = end_tx;
		end else if (offset < end_g1) begin
			phase_nxt = tdwp_pkg::PH_GUARD1;
			bound_nxt = end_g1;
		end else if (offset < end_ack) begin
			phase_nxt = tdwp_pkg::PH_ACK;
			bound_nxt = end_ack;
		end else begin
			phase_nxt = tdwp_pkg::PH_GUARD2;
			bound_nxt = frame;
		end
	end

	always_comb begin
		diff_ext = EXT_BITS'(bound_s1 - offset_s1);
		if (phase_s1 == tdwp_pkg::PH_TX) begin
			hold_nxt = '0;
		end else if (diff_ext > HOLD_MAX) begin
			hold_nxt = '1;
		end else begin
			hold_nxt = diff_ext[tdwp_pkg::HOLD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_out <= 1'b0;
		end else if (en) begin
			vld_s1  <= vld_in;
			vld_out <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phase_s1   <= phase_nxt;
			bound_s1   <= bound_nxt;
			offset_s1  <= offset;
			err_s1     <= err_nxt;
			phase      <= phase_s1;
			rx_hold_ms <= hold_nxt;
			cfg_error  <= err_s1;
		end
	end

endmodule

[rtl/tdd_window_phase_decoder_core.sv]
// Top level of the TDD window phase decoder: configuration registers, input stage,
// divider pipeline and output packing. Depends on tdwp_pkg, tdwp_div_stage, tdwp_phase.

// Each item on the slave stream carries a millisecond timestamp; the block returns one
// result item per timestamp that says where it falls in the repeating frame of transmit
// window, first guard, ACK window and second guard. A new item is accepted in every
// cycle while the output register is empty or being taken. The pipeline is one input
// register, one divider stage per four timestamp bits of the restoring modulo pipeline,
// then a phase compare stage and a remaining-time stage that is also the output
// register. The whole pipeline advances whenever the output register is empty or being
// taken, so a stall on the master side holds every item in place. The three window
// registers may be written only while no item is in flight; the frame length and the
// window ends derived from them are registered once per cycle and are ready for an item
// accepted on the cycle after a write.
module tdd_window_phase_decoder_core #(
	parameter int TIME_BITS   = 32,
	parameter int WINDOW_BITS = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,

	// Configuration write port.
	input  logic                                       cfg_we,
	input  logic [tdwp_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
	input  logic [WINDOW_BITS-1:0]                     cfg_data,

	// Timestamp stream.
	input  logic                                       s_axis_tvalid,
	output logic                                       s_axis_tready,
	// Fields from bit 0 up: time_ms, then zero fill to whole bytes.
	input  logic [((TIME_BITS+7)/8)*8-1:0]             s_axis_tdata,

	// Result stream.
	output logic                                       m_axis_tvalid,
	input  logic                                       m_axis_tready,
	// Fields from bit 0 up: phase (2), tx_allowed, ack_window, force_rx,
	// rx_hold_ms (18), cfg_error.
	output logic [23:0]                                m_axis_tdata
);

	// A frame is at most four windows long, so it needs two bits beyond one window.
	localparam int FRAME_BITS = WINDOW_BITS + 2;
	localparam int NDIV       = (TIME_BITS + tdwp_pkg::DIV_DIGITS - 1) / tdwp_pkg::DIV_DIGITS;
	localparam int DIV_BITS   = NDIV * tdwp_pkg::DIV_DIGITS;

	// Configuration registers.
	logic [WINDOW_BITS-1:0] tx_window_q;
	logic [WINDOW_BITS-1:0] ack_window_q;
	logic [WINDOW_BITS-1:0] guard_q;

	// Window ends measured from the start of the frame.
	logic [FRAME_BITS-1:0] end_tx_q;
	logic [FRAME_BITS-1:0] end_g1_q;
	logic [FRAME_BITS-1:0] end_ack_q;
	logic [FRAME_BITS-1:0] frame_q;

	logic                  adv;
	logic                  vld_s0;
	logic [DIV_BITS-1:0]   time_s0;

	logic                  vld_c  [NDIV+1];
	logic [FRAME_BITS-1:0] rem_c  [NDIV+1];
	logic [DIV_BITS-1:0]   div_c  [NDIV];

	tdwp_pkg::phase_t               phase;
	logic [tdwp_pkg::HOLD_BITS-1:0] rx_hold_ms;
	logic                           cfg_error;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_window_q  <= WINDOW_BITS'(tdwp_pkg::TX_WINDOW_RESET);
			ack_window_q <= WINDOW_BITS'(tdwp_pkg::ACK_WINDOW_RESET);
			guard_q      <= WINDOW_BITS'(tdwp_pkg::GUARD_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				tdwp_pkg::REG_TX_WINDOW:  tx_window_q  <= cfg_data;
				tdwp_pkg::REG_ACK_WINDOW: ack_window_q <= cfg_data;
				tdwp_pkg::REG_GUARD:      guard_q      <= cfg_data;
				default: ; // Writes beyond the register map are dropped.
			endcase
		end
	end

	// The derived bounds follow the registers in the next cycle. No item may be in flight
	// during a write (unchecked), so they settle before any item reaches the divider stages.
	always_ff @(posedge clk) begin
		end_tx_q  <= FRAME_BITS'(tx_window_q);
		end_g1_q  <= FRAME_BITS'(tx_window_q) + FRAME_BITS'(guard_q);
		end_ack_q <= FRAME_BITS'(tx_window_q) + FRAME_BITS'(guard_q)
			+ FRAME_BITS'(ack_window_q);
		frame_q   <= FRAME_BITS'(tx_window_q) + FRAME_BITS'(ack_window_q)
			+ (FRAME_BITS'(guard_q) << 1);
	end

	// The pipeline moves as a whole unless a finished result is waiting to be taken.
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (adv) begin
			vld_s0 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			time_s0 <= DIV_BITS'(s_axis_tdata[TIME_BITS-1:0]);
		end
	end

	assign vld_c[0] = vld_s0;
	assign rem_c[0] = '0;
	assign div_c[0] = time_s0;

	// Divider chain; the last stage keeps only the remainder.
	for (genvar i = 0; i < NDIV; i++) begin : g_div
		if (i < NDIV - 1) begin : g_mid
			tdwp_div_stage #(
				.FRAME_BITS(FRAME_BITS),
				.DIV_BITS  (DIV_BITS)
			) u_stage (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (adv),
				.vld_in (vld_c[i]),
				.rem_in (rem_c[i]),
				.div_in (div_c[i]),
				.frame  (frame_q),
				.vld_out(vld_c[i+1]),
				.rem_out(rem_c[i+1]),
				.div_out(div_c[i+1])
			);
		end else begin : g_last
			tdwp_div_stage #(
				.FRAME_BITS(FRAME_BITS),
				.DIV_BITS  (DIV_BITS)
			) u_stage (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (adv),
				.vld_in (vld_c[i]),
				.rem_in (rem_c[i]),
				.div_in (div_c[i]),
				.frame  (frame_q),
				.vld_out(vld_c[i+1]),
				.rem_out(rem_c[i+1]),
				.div_out()
			);
		end
	end

	tdwp_phase #(
		.FRAME_BITS(FRAME_BITS)
	) u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.vld_in    (vld_c[NDIV]),
		.offset    (rem_c[NDIV]),
		.end_tx    (end_tx_q),
		.end_g1    (end_g1_q),
		.end_ack   (end_ack_q),
		.frame     (frame_q),
		.vld_out   (m_axis_tvalid),
		.phase     (phase),
		.rx_hold_ms(rx_hold_ms),
		.cfg_error (cfg_error)
	);

	// The flags are plain decodes of the registered phase.
	assign m_axis_tdata = {
		cfg_error,
		rx_hold_ms,
		phase != tdwp_pkg::PH_TX,
		phase == tdwp_pkg::PH_ACK,
		phase == tdwp_pkg::PH_TX,
		phase
	};

endmodule

[bench/testbench.sv]
// Self-checking bench for tdd_window_phase_decoder_core: timestamp stream in, phase item out.
// Depends on tdwp_pkg and the core; items are predicted in-bench and checked in order.
`timescale 1ns / 1ps

module testbench;

	// Index 3 is not mapped; a write to it must leave every window untouched.
	localparam logic [tdwp_pkg::CFG_INDEX_BITS-1:0] REG_UNMAPPED = 2'd3;
	localparam int IDLE_PCT       = 23;
	localparam int HOLD_OFF_LEN   = 200;
	localparam int SETTLE_CYCLES  = 16;
	localparam int CYCLE_LIMIT    = 200000;

	// Result item layout, bit 0 at the bottom of the declaration.
	typedef struct packed {
		logic                           cfg_error;
		logic [tdwp_pkg::HOLD_BITS-1:0] rx_hold_ms;
		logic                           force_rx;
		logic                           ack_window;
		logic                           tx_allowed;
		tdwp_pkg::phase_t               phase;
	} frame_result_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_we = 1'b0;
	logic [tdwp_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [15:0]                         cfg_data = '0;
	logic                                s_axis_tvalid = 1'b0;
	logic                                s_axis_tready;
	// Fields from bit 0 up: time_ms.
	logic [31:0]                         s_axis_tdata = '0;
	logic                                m_axis_tvalid;
	logic                                m_axis_tready = 1'b0;
	// Fields from bit 0 up: phase (2), tx_allowed, ack_window, force_rx,
	// rx_hold_ms (18), cfg_error.
	logic [23:0]                         m_axis_tdata;

	tdd_window_phase_decoder_core #(
		.TIME_BITS(32),
		.WINDOW_BITS(16)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copies of the three window registers, as the block should hold them.
	logic [15:0] tx_len = 16'(tdwp_pkg::TX_WINDOW_RESET);
	logic [15:0] ack_len = 16'(tdwp_pkg::ACK_WINDOW_RESET);
	logic [15:0] guard_len = 16'(tdwp_pkg::GUARD_RESET);

	logic [31:0]   stamps_to_send[$];
	frame_result_t phases_due[$];
	int            stamps_queued = 0;
	int            results_seen = 0;
	int            mismatches = 0;
	int            sender_idle_pct = IDLE_PCT;
	int            receiver_idle_pct = IDLE_PCT;
	bit            hold_off_armed = 1'b0;
	bit            hold_off_done = 1'b0;
	int            hold_off_left = 0;
	int            cycle_count = 0;

	// Where a timestamp falls in the frame under the current window lengths. Zero-length
	// windows drop out naturally: the first window whose end lies past the offset wins.
	function automatic frame_result_t decode_timestamp(logic [31:0] stamp);
		longint unsigned frame_len, tx_end, g1_end, ack_end, offs, hold;
		frame_result_t r;
		r = '0;
		hold = 0;
		frame_len = longint'(tx_len) + longint'(ack_len) + 2 * longint'(guard_len);
		tx_end = tx_len;
		g1_end = tx_end + guard_len;
		ack_end = g1_end + ack_len;
		if (frame_len == 0) begin
			// Degenerate frame: flag it and report transmit.
			r.cfg_error = 1'b1;
			r.phase = tdwp_pkg::PH_TX;
		end else begin
			offs = longint'(stamp) % frame_len;
			if (offs < tx_end) begin
				r.phase = tdwp_pkg::PH_TX;
			end else if (offs < g1_end) begin
				r.phase = tdwp_pkg::PH_GUARD1;
				hold = g1_end - offs;
			end else if (offs < ack_end) begin
				r.phase = tdwp_pkg::PH_ACK;
				hold = ack_end - offs;
			end else begin
				r.phase = tdwp_pkg::PH_GUARD2;
				hold = frame_len - offs;
			end
		end
		if (hold > (1 << tdwp_pkg::HOLD_BITS) - 1)
			hold = (1 << tdwp_pkg::HOLD_BITS) - 1;
		r.rx_hold_ms = hold[tdwp_pkg::HOLD_BITS-1:0];
		r.tx_allowed = (r.phase == tdwp_pkg::PH_TX);
		r.ack_window = (r.phase == tdwp_pkg::PH_ACK);
		r.force_rx = (r.phase != tdwp_pkg::PH_TX);
		return r;
	endfunction

	// Sender: one timestamp per handshake. An item stays on the bus until taken; a
	// new one is only presented once the slot is free, so tvalid gets one update per edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				phases_due.push_back(decode_timestamp(s_axis_tdata));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (stamps_to_send.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= stamps_to_send.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Receiver: checks each result item against the oldest prediction. Once armed it
	// refuses items for a long stretch so that the pipeline backs up into the input.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		frame_result_t want, got;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (phases_due.size() == 0) begin
					$error("result item arrived with no timestamp outstanding");
					mismatches++;
				end else begin
					want = phases_due.pop_front();
					got = frame_result_t'(m_axis_tdata);
					check_field("phase", want.phase, got.phase);
					check_field("tx_allowed", want.tx_allowed, got.tx_allowed);
					check_field("ack_window", want.ack_window, got.ack_window);
					check_field("force_rx", want.force_rx, got.force_rx);
					check_field("rx_hold_ms", want.rx_hold_ms, got.rx_hold_ms);
					check_field("cfg_error", want.cfg_error, got.cfg_error);
				end
			end
			if (hold_off_armed && !hold_off_done) begin
				hold_off_left = HOLD_OFF_LEN;
				hold_off_done = 1'b1;
			end
			if (hold_off_left != 0) begin
				hold_off_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
			end
		end
	end

	// Watchdog against a hung pipeline or lost items.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic write_reg(logic [tdwp_pkg::CFG_INDEX_BITS-1:0] idx, logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			tdwp_pkg::REG_TX_WINDOW:  tx_len = value;
			tdwp_pkg::REG_ACK_WINDOW: ack_len = value;
			tdwp_pkg::REG_GUARD:      guard_len = value;
			default: ;
		endcase
	endtask

	// Windows are only rewritten with the pipeline empty, so the shadow copy can
	// change at once.
	task automatic set_windows(logic [15:0] tx, logic [15:0] ack, logic [15:0] guard);
		write_reg(tdwp_pkg::REG_TX_WINDOW, tx);
		write_reg(tdwp_pkg::REG_ACK_WINDOW, ack);
		write_reg(tdwp_pkg::REG_GUARD, guard);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_stamp(logic [31:0] stamp);
		stamps_to_send.push_back(stamp);
		stamps_queued++;
	endtask

	// Most random stamps land within a couple of ms of a window edge in some frame,
	// the rest are drawn from the whole 32-bit range.
	task automatic queue_random_stamps(int count);
		longint unsigned frame_len, edge_pos, frames, stamp;
		int pick;
		frame_len = longint'(tx_len) + longint'(ack_len) + 2 * longint'(guard_len);
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 9);
			if (frame_len == 0 || pick < 4) begin
				queue_stamp($urandom);
			end else begin
				case ($urandom_range(0, 4))
					0: edge_pos = 0;
					1: edge_pos = tx_len;
					2: edge_pos = longint'(tx_len) + guard_len;
					3: edge_pos = longint'(tx_len) + guard_len + ack_len;
					default: edge_pos = frame_len;
				endcase
				frames = 64'h1_0000_0000 / frame_len;
				// A few stamps are pushed toward the top of the timestamp range.
				if (pick == 9)
					stamp = (frames - $urandom_range(0, 2)) * frame_len;
				else
					stamp = ({$urandom, $urandom} % (frames + 1)) * frame_len;
				stamp = stamp + edge_pos + $urandom_range(0, 4) - 2;
				queue_stamp(stamp[31:0]);
			end
		end
	endtask

	// Waits for every queued stamp to come back, then lets the pipeline settle.
	task automatic wait_drained();
		while (results_seen != stamps_queued)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_windows(output logic [15:0] len);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: len = 16'($urandom_range(0, 20));
			5, 6, 7:       len = 16'($urandom_range(0, 1000));
			default:       len = 16'($urandom_range(0, 65535));
		endcase
	endtask

	initial begin : stimulus
		logic [15:0] tx, ack, guard;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset windows (100/10/50/10): every edge of the 170 ms frame, plus both
		// extremes of the timestamp.
		queue_stamp(32'd0);
		queue_stamp(32'd99);
		queue_stamp(32'd100);
		queue_stamp(32'd109);
		queue_stamp(32'd110);
		queue_stamp(32'd159);
		queue_stamp(32'd160);
		queue_stamp(32'd169);
		queue_stamp(32'd170);
		queue_stamp(32'hFFFF_FFFF);
		queue_random_stamps(60);
		wait_drained();

		// All windows zero: the frame is empty and every item flags a bad setup.
		set_windows(16'd0, 16'd0, 16'd0);
		queue_stamp(32'd0);
		queue_stamp(32'hFFFF_FFFF);
		queue_random_stamps(20);
		wait_drained();

		// Widest windows: the longest remaining times the result field must carry.
		set_windows(16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_stamp(32'd65534);
		queue_stamp(32'd65535);
		queue_stamp(32'd131069);
		queue_stamp(32'd131070);
		queue_stamp(32'd196604);
		queue_stamp(32'd196605);
		queue_stamp(32'd262139);
		queue_stamp(32'd262140);
		queue_random_stamps(60);
		wait_drained();

		// Zero-length windows are skipped: only the ACK window is left here.
		set_windows(16'd0, 16'd5, 16'd0);
		queue_stamp(32'd4);
		queue_stamp(32'd5);
		queue_random_stamps(20);
		wait_drained();

		// Transmit only.
		set_windows(16'd3, 16'd0, 16'd0);
		queue_random_stamps(20);
		wait_drained();

		// Guards only: first guard runs straight into the second.
		set_windows(16'd0, 16'd0, 16'd7);
		queue_stamp(32'd6);
		queue_stamp(32'd7);
		queue_random_stamps(20);
		wait_drained();

		// A write to the unmapped index must change nothing.
		write_reg(REG_UNMAPPED, 16'($urandom));
		@(posedge clk);
		cfg_we <= 1'b0;
		queue_random_stamps(20);
		wait_drained();

		// Random window settings; one phase runs with no idling on either side and
		// another has the receiver hold off while stamps keep coming.
		for (int ph = 0; ph < 8; ph++) begin
			random_windows(tx);
			random_windows(ack);
			random_windows(guard);
			set_windows(tx, ack, guard);
			sender_idle_pct = (ph == 2) ? 0 : IDLE_PCT;
			receiver_idle_pct = (ph == 2) ? 0 : IDLE_PCT;
			if (ph == 5)
				hold_off_armed = 1'b1;
			queue_random_stamps(95);
			wait_drained();
		end

		if (mismatches == 0 && phases_due.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/tdwp_pkg.sv
rtl/tdwp_div_stage.sv
rtl/tdwp_phase.sv
rtl/tdd_window_phase_decoder_core.sv
bench/testbench.sv
